// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/sapm_pkg.sv =====
// ----------------------------------------------------------------------------
// sapm_pkg
// Types, constants and helpers shared by the silence alarm monitor modules.
// ----------------------------------------------------------------------------
package sapm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TICK_W          = 32;
    localparam int CNT_DEPTH       = 96;
    localparam int CNT_ADDR_W      = 7;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_THRESHOLD   = 2'd0;
    localparam cfg_idx_t CFG_MONO_MASK   = 2'd1;
    localparam cfg_idx_t CFG_STEREO_MASK = 2'd2;

    typedef logic [1:0] byte_sel_t;
    localparam byte_sel_t SEL_MONO_EVEN = 2'd0;
    localparam byte_sel_t SEL_MONO_ODD  = 2'd1;
    localparam byte_sel_t SEL_STEREO    = 2'd2;

    localparam logic EV_OFF_AIR  = 1'b0;
    localparam logic EV_RESTORED = 1'b1;

    typedef struct packed {
        logic        load;
        logic        rd;
        logic        upd;
        logic        off;
        logic        flush;
        byte_sel_t   byte_sel;
        logic [2:0]  bit_idx;
    } sapm_cmd_t;

    typedef struct packed {
        logic restore_hit;
        logic reach_bit;
        logic emit_stall;
        logic held_valid;
    } sapm_status_t;

    typedef struct packed {
        logic              kind;
        logic              stereo;
        logic [5:0]        chan;
        logic [TICK_W-1:0] ticks;
    } sapm_event_t;

    function automatic logic [3:0] pairs_to_nibble(input logic [7:0] b);
        logic [3:0] nib;
        for (int k = 0; k < 4; k++) begin
            nib[k] = b[2*k] & b[2*k+1];
        end
        return nib;
    endfunction

endpackage

// ===== rtl/silence_alarm_persistence_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// silence_alarm_persistence_monitor_unit
// Counts ticks of continuous audio-loss alarm for 64 mono channels and 32
// stereo pairs and reports off-air and restored events.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_       in   tdata {alarm_odd, alarm_even}, tuser pair_index
// m_       out  tdata {silence_ticks, channel_number}, tuser {is_stereo,
//               event_kind}, tlast last_event
// cfg_     in   cfg_index register, cfg_data value
//
// An item occupies the block from its accept through a read and a write-back for each
// of 24 counters on the single memory port, an off-air scan per alarm byte and a drain;
// no new item is taken until the drain ends.
// Reset clears all counters at once through per-entry valid bits.
// A stalled result beat holds the sequencer when another event is due or the last
// event of the item still waits for the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module silence_alarm_persistence_monitor_unit import sapm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] alarm_even, [15:8] alarm_odd
    input  logic [1:0]  s_tuser,   // [1:0] pair_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] channel_number, [37:6] silence_ticks, zero
    output logic [1:0]  m_tuser,   // [0] event_kind, [1] is_stereo
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    sapm_cmd_t    ctrl_cmd;
    sapm_status_t dp_status;
    sapm_event_t  out_event;
    logic [4:0]   cmd_bits;

    assign cfg_ready = 1'b1;

    sapm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    sapm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_pair   (s_tuser),
        .in_even   (s_tdata[7:0]),
        .in_odd    (s_tdata[15:8]),
        .cmd       (ctrl_cmd),
        .status    (dp_status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_event   (out_event),
        .m_last    (m_tlast)
    );

    assign m_tdata = {2'b00, out_event.ticks, out_event.chan};
    assign m_tuser = {out_event.stereo, out_event.kind};

    assign cmd_bits = {ctrl_cmd.load, ctrl_cmd.rd, ctrl_cmd.upd, ctrl_cmd.off,
                       ctrl_cmd.flush};

    `ASSERT_AT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input accepted twice in a row")
    `ASSERT_NEVER(a_accept_with_held, aclk, aresetn, s_tvalid && s_tready && dp_status.held_valid, "item accepted with an undelivered event")
    `ASSERT_AT(a_one_command, aclk, aresetn, $onehot0(cmd_bits), "more than one datapath command")

endmodule

// ===== rtl/sapm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sapm_ctrl
// Sequencer that walks the 24 channel counters of one item and drains events.
// ----------------------------------------------------------------------------
module sapm_ctrl import sapm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  sapm_status_t status,
    output sapm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_OFFAIR,
        ST_FLUSH
    } state_t;

    state_t     state_reg;
    byte_sel_t  byte_reg;
    logic [2:0] bit_reg;

    logic upd_go;
    logic off_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign upd_go   = !(status.restore_hit && status.emit_stall);
    assign off_go   = !(status.reach_bit && status.emit_stall);

    always_comb begin
        cmd          = '0;
        cmd.byte_sel = byte_reg;
        cmd.bit_idx  = bit_reg;
        case (state_reg)
            ST_IDLE:   cmd.load  = s_tvalid;
            ST_READ:   cmd.rd    = 1'b1;
            ST_UPDATE: cmd.upd   = upd_go;
            ST_OFFAIR: cmd.off   = off_go;
            ST_FLUSH:  cmd.flush = 1'b1;
            default:   cmd       = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            byte_reg  <= SEL_MONO_EVEN;
            bit_reg   <= 3'd7;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        byte_reg  <= SEL_MONO_EVEN;
                        bit_reg   <= 3'd7;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (upd_go) begin
                        if (bit_reg == 3'd0) begin
                            state_reg <= ST_OFFAIR;
                        end else begin
                            bit_reg   <= bit_reg - 3'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_OFFAIR: begin
                    if (off_go) begin
                        if (bit_reg == 3'd7) begin
                            if (byte_reg == SEL_STEREO) begin
                                state_reg <= ST_FLUSH;
                            end else begin
                                byte_reg  <= byte_reg + 2'd1;
                                state_reg <= ST_READ;
                            end
                        end else begin
                            bit_reg <= bit_reg + 3'd1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!status.held_valid) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/sapm_dp.sv =====
// ----------------------------------------------------------------------------
// sapm_dp
// Configuration, counter memory, update logic and the event output stage.
// ----------------------------------------------------------------------------
module sapm_dp import sapm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  cfg_idx_t          cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic [1:0]        in_pair,
    input  logic [7:0]        in_even,
    input  logic [7:0]        in_odd,
    input  sapm_cmd_t         cmd,
    output sapm_status_t      status,
    input  logic              m_tready,
    output logic              m_tvalid,
    output sapm_event_t       m_event,
    output logic              m_last
);

    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [CMP_W-1:0] TICK_MAX = CMP_W'({TICK_W{1'b1}});

    logic [TICK_W-1:0] thr_reg;
    logic [63:0]       mono_en_reg;
    logic [31:0]       stereo_en_reg;

    logic [1:0] pair_reg;
    logic [7:0] alarm_even_reg;
    logic [7:0] alarm_odd_reg;
    logic [7:0] alarm_st_reg;

    logic [COUNT_WIDTH-1:0] cnt_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0]   cnt_vld_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic [7:0]             reached_reg;

    sapm_event_t held_reg;
    logic        held_valid_reg;
    sapm_event_t out_reg;
    logic        out_last_reg;
    logic        out_valid_reg;

    logic [CNT_ADDR_W-1:0]  addr;
    logic [7:0]             cur_alarm;
    logic                   alarm_bit;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic [TICK_W-1:0]      thr_eff;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       thr_ext;
    logic [CMP_W-1:0]       inc_ext;
    logic [TICK_W-1:0]      ticks_sat;
    logic                   reach;
    logic                   restore_hit;
    logic                   push_restore;
    logic                   push_off;
    logic                   push;
    logic                   out_free;
    logic                   move;
    sapm_event_t            new_event;

    always_comb begin
        case (cmd.byte_sel)
            SEL_MONO_EVEN: begin
                addr      = {1'b0, pair_reg, 1'b0, cmd.bit_idx};
                cur_alarm = alarm_even_reg;
            end
            SEL_MONO_ODD: begin
                addr      = {1'b0, pair_reg, 1'b1, cmd.bit_idx};
                cur_alarm = alarm_odd_reg;
            end
            SEL_STEREO: begin
                addr      = {2'b10, pair_reg, cmd.bit_idx};
                cur_alarm = alarm_st_reg;
            end
            default: begin
                addr      = '0;
                cur_alarm = '0;
            end
        endcase
    end

    assign alarm_bit = cur_alarm[cmd.bit_idx];
    assign cur_cnt   = rd_vld_reg ? rd_data_reg : '0;
    assign thr_eff   = (thr_reg == '0) ? TICK_W'(1) : thr_reg;
    assign cnt_ext   = CMP_W'(cur_cnt);
    assign thr_ext   = CMP_W'(thr_eff);
    assign inc_ext   = CMP_W'(cur_cnt + COUNT_WIDTH'(1));
    assign ticks_sat = (cnt_ext > TICK_MAX) ? {TICK_W{1'b1}} : cnt_ext[TICK_W-1:0];

    always_comb begin
        new_cnt     = '0;
        reach       = 1'b0;
        restore_hit = 1'b0;
        if (alarm_bit) begin
            if (cur_cnt != CNT_MAX) begin
                new_cnt = cur_cnt + COUNT_WIDTH'(1);
                reach   = (inc_ext == thr_ext);
            end else begin
                new_cnt = cur_cnt;
            end
        end else begin
            restore_hit = (cnt_ext >= thr_ext);
        end
    end

    assign push_restore = cmd.upd && restore_hit;
    assign push_off     = cmd.off && reached_reg[cmd.bit_idx];
    assign push         = push_restore || push_off;
    assign out_free     = !out_valid_reg || m_tready;
    assign move         = held_valid_reg && (push || (cmd.flush && out_free));

    always_comb begin
        new_event.kind   = push_restore ? EV_RESTORED : EV_OFF_AIR;
        new_event.stereo = (cmd.byte_sel == SEL_STEREO);
        new_event.chan   = addr[5:0];
        new_event.ticks  = push_restore ? ticks_sat : thr_eff;
    end

    assign status.restore_hit = restore_hit;
    assign status.reach_bit   = reached_reg[cmd.bit_idx];
    assign status.emit_stall  = held_valid_reg && !out_free;
    assign status.held_valid  = held_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_event  = out_reg;
    assign m_last   = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= TICK_W'(1);
            mono_en_reg   <= '0;
            stereo_en_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD:   thr_reg       <= cfg_data[TICK_W-1:0];
                CFG_MONO_MASK:   mono_en_reg   <= cfg_data;
                CFG_STEREO_MASK: stereo_en_reg <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pair_reg       <= in_pair;
            alarm_even_reg <= in_even & mono_en_reg[{in_pair, 1'b0, 3'b000} +: 8];
            alarm_odd_reg  <= in_odd & mono_en_reg[{in_pair, 1'b1, 3'b000} +: 8];
            alarm_st_reg   <= {pairs_to_nibble(in_odd), pairs_to_nibble(in_even)}
                              & stereo_en_reg[{in_pair, 3'b000} +: 8];
        end
        if (cmd.upd) begin
            reached_reg[cmd.bit_idx] <= reach;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            cnt_mem[addr] <= new_cnt;
        end
        if (cmd.rd) begin
            rd_data_reg <= cnt_mem[addr];
            rd_vld_reg  <= cnt_vld_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (cmd.upd) begin
            cnt_vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (push) begin
                held_valid_reg <= 1'b1;
            end else if (move) begin
                held_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            held_reg <= new_event;
        end
        if (move) begin
            out_reg      <= held_reg;
            out_last_reg <= !push;
        end
    end

endmodule
